### rtl/core/ckc_pkg.sv
`timescale 1ns / 1ps

package ckc_pkg;

	localparam int PIX_W      = 8;
	localparam int KEY_W      = 2;
	localparam int LIMIT_W    = 18;
	localparam int FW_W       = 13;
	localparam int SQ_W       = 2 * PIX_W;
	localparam int DIST_W     = 18;
	localparam int SUM_W      = 36;
	localparam int CNT_W      = 25;
	localparam int CEN_W      = 16;
	localparam int FRAC_W     = 4;
	localparam int DVD_W      = SUM_W + FRAC_W;
	localparam int DIV_STEPS  = DVD_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_SELECT     = 2'd0,
		REG_DISTANCE_LIMIT = 2'd1,
		REG_FRAME_WIDTH    = 2'd2
	} reg_idx_t;

	typedef enum logic [KEY_W-1:0] {
		KEY_MAGENTA_RED = 2'd0,
		KEY_CYAN_GREEN  = 2'd1,
		KEY_BLUE        = 2'd2,
		KEY_BLACK       = 2'd3
	} key_t;

	localparam logic [KEY_W-1:0]   KEY_RESET   = KEY_MAGENTA_RED;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 18'd900;
	localparam logic [FW_W-1:0]    FW_RESET    = 13'd640;

	typedef struct packed {
		logic [PIX_W-1:0] r;
		logic [PIX_W-1:0] g;
		logic [PIX_W-1:0] b;
	} rgb_t;

	// controller -> datapath
	typedef struct packed {
		logic accum;
		logic last;
		logic load;
		logic zero;
		logic step;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic any_match;
		logic div_last;
	} sts_t;

	function automatic rgb_t key_color(input logic [KEY_W-1:0] sel);
		rgb_t c;
		case (key_t'(sel))
			KEY_MAGENTA_RED: c = '{r: 8'd253, g: 8'd17,  b: 8'd251};
			KEY_CYAN_GREEN:  c = '{r: 8'd19,  g: 8'd251, b: 8'd233};
			KEY_BLUE:        c = '{r: 8'd13,  g: 8'd97,  b: 8'd255};
			KEY_BLACK:       c = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
			default:         c = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
		endcase
		return c;
	endfunction

endpackage

### rtl/core/ckc_if.sv
`timescale 1ns / 1ps

interface ckc_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_red;
	logic [7:0] pixel_green;
	logic [7:0] pixel_blue;
	logic       frame_end;

	modport source(output valid, pixel_red, pixel_green, pixel_blue, frame_end, input ready);
	modport sink(input valid, pixel_red, pixel_green, pixel_blue, frame_end, output ready);
endinterface

interface ckc_result_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [15:0] centroid_x;
	logic [15:0] centroid_y;

	modport source(output valid, found, centroid_x, centroid_y, input ready);
	modport sink(input valid, found, centroid_x, centroid_y, output ready);
endinterface

### rtl/core/ckc_ctrl.sv
`timescale 1ns / 1ps

module ckc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  ckc_pkg::sts_t sts,
	output ckc_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   accept;

	// ordinary pixels always flow; a frame end waits for the divider and result slot
	assign in_ready  = (state_q == S_IDLE) || !in_last;
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd       = '0;
		cmd.accum = accept;
		cmd.last  = in_last;
		cmd.load  = accept && in_last && sts.any_match;
		cmd.zero  = accept && in_last && !sts.any_match;
		cmd.step  = (state_q == S_DIV);
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && in_last) begin
					state_nx = sts.any_match ? S_DIV : S_OUT;
				end
			end
			S_DIV: begin
				if (sts.div_last) begin
					state_nx = S_OUT;
				end
			end
			S_OUT: begin
				if (out_ready) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	a_load_starts_divide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_DIV)
		else $error("divide did not start after load");

	a_divide_runs_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && !sts.div_last) |=> state_q == S_DIV)
		else $error("divide left early");

endmodule

### rtl/core/ckc_dp.sv
`timescale 1ns / 1ps

module ckc_dp #(
	parameter int MAX_DIM = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [ckc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ckc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [ckc_pkg::PIX_W-1:0]        pixel_red,
	input  logic [ckc_pkg::PIX_W-1:0]        pixel_green,
	input  logic [ckc_pkg::PIX_W-1:0]        pixel_blue,
	input  ckc_pkg::cmd_t                    cmd,
	output ckc_pkg::sts_t                    sts,
	output logic                             found,
	output logic [ckc_pkg::CEN_W-1:0]        centroid_x,
	output logic [ckc_pkg::CEN_W-1:0]        centroid_y
);

	localparam int CW = $clog2(MAX_DIM);
	localparam int WW = CW + 1;

	localparam int SUM_W  = ckc_pkg::SUM_W;
	localparam int CNT_W  = ckc_pkg::CNT_W;
	localparam int DVD_W  = ckc_pkg::DVD_W;
	localparam int CEN_W  = ckc_pkg::CEN_W;
	localparam int SQ_W   = ckc_pkg::SQ_W;
	localparam int DIST_W = ckc_pkg::DIST_W;
	localparam int STEP_W = ckc_pkg::STEP_W;

	// configuration
	logic [ckc_pkg::KEY_W-1:0]   key_q;
	logic [ckc_pkg::LIMIT_W-1:0] limit_q;
	logic [ckc_pkg::FW_W-1:0]    fwidth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= ckc_pkg::KEY_RESET;
			limit_q  <= ckc_pkg::LIMIT_RESET;
			fwidth_q <= ckc_pkg::FW_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				ckc_pkg::REG_KEY_SELECT:     key_q    <= cfg_data[ckc_pkg::KEY_W-1:0];
				ckc_pkg::REG_DISTANCE_LIMIT: limit_q  <= cfg_data[ckc_pkg::LIMIT_W-1:0];
				ckc_pkg::REG_FRAME_WIDTH:    fwidth_q <= cfg_data[ckc_pkg::FW_W-1:0];
				default: ;
			endcase
		end
	end

	// match test
	ckc_pkg::rgb_t            key;
	logic [ckc_pkg::PIX_W-1:0] d_r, d_g, d_b;
	logic [SQ_W-1:0]          sq_r, sq_g, sq_b;
	logic [DIST_W-1:0]        dist_sq;
	logic                     match;

	always_comb begin
		key     = ckc_pkg::key_color(key_q);
		d_r     = (pixel_red   >= key.r) ? pixel_red   - key.r : key.r - pixel_red;
		d_g     = (pixel_green >= key.g) ? pixel_green - key.g : key.g - pixel_green;
		d_b     = (pixel_blue  >= key.b) ? pixel_blue  - key.b : key.b - pixel_blue;
		sq_r    = SQ_W'(d_r) * SQ_W'(d_r);
		sq_g    = SQ_W'(d_g) * SQ_W'(d_g);
		sq_b    = SQ_W'(d_b) * SQ_W'(d_b);
		dist_sq = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
		match   = (dist_sq <= limit_q);
	end

	// raster position and accumulators
	logic [CW-1:0]    col_q, row_q, col_nx, row_nx;
	logic [WW-1:0]    width_eff, col_inc;
	logic             wrap;
	logic [SUM_W-1:0] sum_x_q, sum_y_q, sum_x_nx, sum_y_nx;
	logic [SUM_W:0]   sum_x_add, sum_y_add;
	logic [CNT_W-1:0] cnt_q, cnt_nx;

	always_comb begin
		if (fwidth_q == '0) begin
			width_eff = WW'(1);
		end else if (int'(fwidth_q) > MAX_DIM) begin
			width_eff = WW'(MAX_DIM);
		end else begin
			width_eff = WW'(fwidth_q);
		end
		col_inc = WW'(col_q) + WW'(1);
		wrap    = (col_inc >= width_eff);
		col_nx  = wrap ? '0 : col_inc[CW-1:0];
		row_nx  = (wrap && row_q != CW'(MAX_DIM - 1)) ? row_q + CW'(1) : row_q;

		sum_x_add = {1'b0, sum_x_q} + (SUM_W + 1)'(col_q);
		sum_y_add = {1'b0, sum_y_q} + (SUM_W + 1)'(row_q);
		sum_x_nx  = sum_x_q;
		sum_y_nx  = sum_y_q;
		cnt_nx    = cnt_q;
		if (match) begin
			sum_x_nx = sum_x_add[SUM_W] ? '1 : sum_x_add[SUM_W-1:0];
			sum_y_nx = sum_y_add[SUM_W] ? '1 : sum_y_add[SUM_W-1:0];
			if (cnt_q != '1) begin
				cnt_nx = cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			cnt_q   <= '0;
		end else if (cmd.accum) begin
			if (cmd.last) begin
				col_q   <= '0;
				row_q   <= '0;
				sum_x_q <= '0;
				sum_y_q <= '0;
				cnt_q   <= '0;
			end else begin
				col_q   <= col_nx;
				row_q   <= row_nx;
				sum_x_q <= sum_x_nx;
				sum_y_q <= sum_y_nx;
				cnt_q   <= cnt_nx;
			end
		end
	end

	// bit-serial restoring divider, lane 0 for x and lane 1 for y
	logic [DVD_W-1:0]  dvd_q  [2];
	logic [CNT_W-1:0]  rem_q  [2];
	logic [CNT_W-1:0]  rem_nx [2];
	logic [CEN_W-1:0]  quo_q  [2];
	logic [CEN_W-1:0]  quo_nx [2];
	logic [CEN_W-1:0]  res    [2];
	logic              ovf_q  [2];
	logic              ovf_nx [2];
	logic [CNT_W:0]    shifted[2];
	logic              ge     [2];
	logic [CNT_W-1:0]  div_q;
	logic [STEP_W-1:0] step_q;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			shifted[l] = {rem_q[l], dvd_q[l][DVD_W-1]};
			ge[l]      = (shifted[l] >= {1'b0, div_q});
			rem_nx[l]  = ge[l] ? CNT_W'(shifted[l] - {1'b0, div_q}) : CNT_W'(shifted[l]);
			quo_nx[l]  = {quo_q[l][CEN_W-2:0], ge[l]};
			// sticky overflow: any quotient bit above the 16 kept ones saturates
			ovf_nx[l]  = ovf_q[l] | quo_q[l][CEN_W-1];
			res[l]     = ovf_nx[l] ? '1 : quo_nx[l];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q[0] <= {sum_x_nx, {ckc_pkg::FRAC_W{1'b0}}};
			dvd_q[1] <= {sum_y_nx, {ckc_pkg::FRAC_W{1'b0}}};
			div_q    <= cnt_nx;
			step_q   <= '0;
			for (int l = 0; l < 2; l++) begin
				rem_q[l] <= '0;
				quo_q[l] <= '0;
				ovf_q[l] <= 1'b0;
			end
		end else if (cmd.step) begin
			step_q <= step_q + STEP_W'(1);
			for (int l = 0; l < 2; l++) begin
				dvd_q[l] <= {dvd_q[l][DVD_W-2:0], 1'b0};
				rem_q[l] <= rem_nx[l];
				quo_q[l] <= quo_nx[l];
				ovf_q[l] <= ovf_nx[l];
			end
		end
	end

	assign sts.any_match = (cnt_nx != '0);
	assign sts.div_last  = (step_q == STEP_W'(ckc_pkg::DIV_STEPS - 1));

	// result register
	logic             found_q;
	logic [CEN_W-1:0] cx_q, cy_q;

	always_ff @(posedge clk) begin
		if (cmd.zero) begin
			found_q <= 1'b0;
			cx_q    <= '0;
			cy_q    <= '0;
		end else if (cmd.step && sts.div_last) begin
			found_q <= 1'b1;
			cx_q    <= res[0];
			cy_q    <= res[1];
		end
	end

	assign found      = found_q;
	assign centroid_x = cx_q;
	assign centroid_y = cy_q;

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (rem_q[0] < div_q) && (rem_q[1] < div_q))
		else $error("divider remainder not below divisor");

	a_empty_frame_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.zero |=> !found_q && cx_q == '0 && cy_q == '0)
		else $error("empty frame result not zero");

	a_frame_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accum && cmd.last) |=> cnt_q == '0 && sum_x_q == '0 && sum_y_q == '0
			&& col_q == '0 && row_q == '0)
		else $error("state not cleared after frame end");

endmodule

### rtl/core/color_key_centroid_core.sv
`timescale 1ns / 1ps
// port     dir  contents
// pixel    in   valid/ready, pixel_red, pixel_green, pixel_blue, frame_end
// result   out  valid/ready, found, centroid_x, centroid_y
// cfg_*    in   cfg_write, cfg_index, cfg_data (write only)
//
// One pixel per clock is accepted; pixels that do not end a frame are never stalled.
// A frame end with a match starts a bit-serial divide (one quotient bit per cycle for both
// axes); the result shows as it ends, or in the cycle after acceptance if nothing matched.
// The next frame accumulates meanwhile; its frame end stalls until the previous result
// transfers. arst_n clears position, sums, count, controller and registers to defaults.

module color_key_centroid_core #(
	parameter int MAX_DIM = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ckc_pixel_if.sink                      pixel,
	ckc_result_if.source                   result,
	input  logic                           cfg_write,
	input  logic [ckc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ckc_pkg::CFG_DATA_W-1:0] cfg_data
);

	ckc_pkg::cmd_t cmd;
	ckc_pkg::sts_t sts;
	logic          in_ready;
	logic          out_valid;

	ckc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_last   (pixel.frame_end),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ckc_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_red   (pixel.pixel_red),
		.pixel_green (pixel.pixel_green),
		.pixel_blue  (pixel.pixel_blue),
		.cmd         (cmd),
		.sts         (sts),
		.found       (result.found),
		.centroid_x  (result.centroid_x),
		.centroid_y  (result.centroid_y)
	);

	assign pixel.ready  = in_ready;
	assign result.valid = out_valid;

endmodule
